[design/fpff_pkg.sv]
// -----------------------------------------------------------------------------
// fpff_pkg
// Shared widths, request and result codes, operation codes and bus types of
// the partition allocator.
// -----------------------------------------------------------------------------
package fpff_pkg;

  localparam int SIZE_BITS     = 16;
  localparam int ID_W          = 4;
  localparam int NUM_PARTS_DEF = 8;
  localparam int NUM_PROCS_DEF = 16;

  // Widths cover the full partition range (up to 64 cells)
  localparam int MAX_PARTS = 64;
  localparam int PIDX_W    = $clog2(MAX_PARTS);
  localparam int CNT_W     = PIDX_W + 1;
  localparam int SUM_W     = SIZE_BITS + PIDX_W;

  // Request modes as they appear on in_mode
  typedef enum logic [1:0] {
    MODE_DEFINE  = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // Result codes as they appear on out_status
  typedef enum logic [2:0] {
    ST_ALLOC    = 3'd0,
    ST_EXT_FRAG = 3'd1,
    ST_NO_MEM   = 3'd2,
    ST_DEFINED  = 3'd3,
    ST_RELEASED = 3'd4,
    ST_INVALID  = 3'd5
  } status_t;

  typedef logic [1:0] op_t;
  localparam op_t OP_RECOUNT = 2'd0;
  localparam op_t OP_DEFINE  = 2'd1;
  localparam op_t OP_ALLOC   = 2'd2;
  localparam op_t OP_RELEASE = 2'd3;

  // Broadcast to every cell, held for a whole pass
  typedef struct packed {
    op_t                 op;
    logic                free_en;
    logic [PIDX_W-1:0]   free_idx;
    logic [PIDX_W-1:0]   def_idx;
    logic [SIZE_BITS-1:0] def_size;
    logic [SIZE_BITS-1:0] req;
    logic [CNT_W-1:0]    searched;
  } cell_ctl_t;

  // Travels from cell to cell, one hop a cycle
  typedef struct packed {
    logic                 vld;
    logic                 found;
    logic [PIDX_W-1:0]    gidx;
    logic [SIZE_BITS-1:0] gsize;
    logic [SUM_W-1:0]     sum;
    logic [CNT_W-1:0]     bcnt;
  } token_t;

  typedef struct packed {
    logic              set_en;
    logic [ID_W-1:0]   set_id;
    logic [PIDX_W-1:0] set_part;
    logic              clr_en;
    logic [ID_W-1:0]   clr_id;
  } ptab_upd_t;

endpackage

[design/fixed_partition_first_fit.sv]
// -----------------------------------------------------------------------------
// fixed_partition_first_fit
// Fixed-partition allocator with first-fit placement over a row of cells.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per transfer, mode 0
//   defines a partition size, 1 allocates a process, 2 releases one.
//   Output channel (out_valid / out_stall): exactly one result per request,
//   in request order.
//   Config channel (cfg_valid / cfg_ready): writes blocks_in_use; taken only
//   while the block is idle, and followed by a recount pass that produces no
//   result.
//   Flow: an accepted request is registered together with its table lookup,
//   the pass is decided from the lookup, and the pass token then walks the
//   partition cells one per cycle before the result loads the output
//   register. One request is in work at a time, so a new request is taken
//   only after the result of the last one has been loaded.
//   A finished result waits in the output register; the next request is
//   accepted meanwhile, and its pass holds at the end until the slot frees.
//   Reset (synchronous, active low) clears all sizes, busy flags and process
//   holdings, and sets blocks_in_use to 8.
// -----------------------------------------------------------------------------
module fixed_partition_first_fit import fpff_pkg::*; #(
  parameter int NUM_PARTS = NUM_PARTS_DEF,
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [2:0]  in_part_index,
  input  logic [15:0] in_part_size,
  input  logic [3:0]  in_proc_id,
  input  logic [15:0] in_proc_size,
  input  logic [3:0]  in_victim_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_granted_part,
  output logic [15:0] out_internal_frag,
  output logic [18:0] out_free_total,
  output logic        out_evicted,
  output logic [2:0]  out_evicted_part,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_blocks_in_use
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [3:0]       cfg_r;
  logic             cfg_pass_r;
  logic [CNT_W-1:0] busy_cnt_r;
  logic             out_valid_r;

  // request payload
  logic [1:0]           mode_r;
  logic [2:0]           pidx_r;
  logic [SIZE_BITS-1:0] psz_r;
  logic [ID_W-1:0]      pid_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [ID_W-1:0]      vid_r;

  // pass setup
  cell_ctl_t         ctl_r, ctl_nxt, ctl_bus;
  logic [2:0]        pend_status_r, pend_status_nxt;
  logic              ev_r, ev_nxt;
  logic [PIDX_W-1:0] evp_r, evp_nxt;

  // result register
  logic [2:0]  out_status_r;
  logic [2:0]  out_granted_r;
  logic [15:0] out_frag_r;
  logic [18:0] out_free_r;
  logic        out_ev_r;
  logic [2:0]  out_evp_r;

  logic [CNT_W-1:0]  searched_c;
  logic              in_acc;
  logic              cfg_acc;
  logic              pass_end;
  logic              out_load;
  token_t            tok_start;
  token_t            tok_end;
  logic [PIDX_W-1:0] rd_part;
  logic              pid_holds;
  logic              vid_holds;
  ptab_upd_t         upd;
  logic [SUM_W-1:0]  final_sum;
  logic [2:0]        res_status;

  // blocks_in_use clamps to 1 .. NUM_PARTS
  always_comb begin
    if (cfg_r == '0) begin
      searched_c = CNT_W'(1);
    end else if (int'(cfg_r) > NUM_PARTS) begin
      searched_c = CNT_W'(NUM_PARTS);
    end else begin
      searched_c = CNT_W'(cfg_r);
    end
  end

  // Config has priority in idle; requests wait behind it
  assign cfg_ready = (state_r == S_IDLE);
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;

  // Process table: read the victim (allocate) or the process (release)
  fpff_ptab #(
    .NUM_PROCS(NUM_PROCS)
  ) u_ptab (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_id    ((in_mode == MODE_RELEASE) ? in_proc_id : in_victim_id),
    .rd_part  (rd_part),
    .pid      (pid_r),
    .vid      (vid_r),
    .pid_holds(pid_holds),
    .vid_holds(vid_holds),
    .upd      (upd)
  );

  // Decide the pass from the request and the table lookup
  always_comb begin
    ctl_nxt          = '0;
    ctl_nxt.op       = OP_RECOUNT;
    ctl_nxt.free_idx = rd_part;
    ctl_nxt.def_idx  = PIDX_W'(pidx_r);
    ctl_nxt.def_size = psz_r;
    ctl_nxt.req      = req_r;
    ctl_nxt.searched = searched_c;
    pend_status_nxt  = ST_INVALID;
    ev_nxt           = 1'b0;
    evp_nxt          = '0;
    case (mode_r)
      MODE_DEFINE: begin
        if (int'(pidx_r) < NUM_PARTS) begin
          ctl_nxt.op      = OP_DEFINE;
          pend_status_nxt = ST_DEFINED;
        end
      end
      MODE_ALLOC: begin
        if ((int'(pid_r) < NUM_PROCS) && !pid_holds) begin
          if (busy_cnt_r < searched_c) begin
            ctl_nxt.op = OP_ALLOC;
          end else if ((int'(vid_r) < NUM_PROCS) && vid_holds) begin
            // every searched partition is taken: evict the victim first
            ctl_nxt.op      = OP_ALLOC;
            ctl_nxt.free_en = 1'b1;
            ev_nxt          = 1'b1;
            evp_nxt         = rd_part;
          end
        end
      end
      MODE_RELEASE: begin
        if ((int'(pid_r) < NUM_PROCS) && pid_holds) begin
          ctl_nxt.op      = OP_RELEASE;
          ctl_nxt.free_en = 1'b1;
          pend_status_nxt = ST_RELEASED;
        end
      end
      default: begin
      end
    endcase
  end

  // searched follows the live register, so a recount sees a fresh write
  always_comb begin
    ctl_bus          = ctl_r;
    ctl_bus.searched = searched_c;
  end

  always_comb begin
    tok_start     = '0;
    tok_start.vld = (state_r == S_LAUNCH);
  end

  fpff_chain #(
    .NUM_PARTS(NUM_PARTS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl_bus),
    .tok_start(tok_start),
    .tok_end  (tok_end)
  );

  // Result from the token that left the last cell; its payload holds
  always_comb begin
    final_sum = tok_end.sum - (tok_end.found ? SUM_W'(tok_end.gsize) : SUM_W'(0));
    if (ctl_r.op == OP_ALLOC) begin
      if (tok_end.found) begin
        res_status = ST_ALLOC;
      end else if (tok_end.sum >= SUM_W'(ctl_r.req)) begin
        res_status = ST_EXT_FRAG;
      end else begin
        res_status = ST_NO_MEM;
      end
    end else begin
      res_status = pend_status_r;
    end
  end

  assign pass_end = (state_r == S_RUN) && tok_end.vld;
  assign out_load = ((pass_end && !cfg_pass_r) || (state_r == S_DONE)) &&
                    (!out_valid_r || !out_stall);

  // Commit holdings at the end of a request pass
  always_comb begin
    upd          = '0;
    upd.set_id   = pid_r;
    upd.set_part = tok_end.gidx;
    upd.clr_id   = (ctl_r.op == OP_RELEASE) ? pid_r : vid_r;
    if (pass_end && !cfg_pass_r) begin
      upd.set_en = tok_end.found;
      upd.clr_en = ctl_r.free_en;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_acc) begin
          state_nxt = S_LAUNCH;
        end else if (in_acc) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:   state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_RUN;
      S_RUN: begin
        if (tok_end.vld) begin
          if (cfg_pass_r || out_load) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= 4'd8;
      cfg_pass_r  <= 1'b0;
      busy_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        cfg_r      <= cfg_blocks_in_use;
        cfg_pass_r <= 1'b1;
      end else if (in_acc) begin
        cfg_pass_r <= 1'b0;
      end
      if (pass_end) begin
        busy_cnt_r <= tok_end.bcnt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_mode;
      pidx_r <= in_part_index;
      psz_r  <= in_part_size;
      pid_r  <= in_proc_id;
      req_r  <= in_proc_size;
      vid_r  <= in_victim_id;
    end
    if (cfg_acc) begin
      ctl_r         <= '0;
      pend_status_r <= ST_INVALID;
      ev_r          <= 1'b0;
      evp_r         <= '0;
    end else if (state_r == S_LOOK) begin
      ctl_r         <= ctl_nxt;
      pend_status_r <= pend_status_nxt;
      ev_r          <= ev_nxt;
      evp_r         <= evp_nxt;
    end
    if (out_load) begin
      out_status_r  <= res_status;
      out_granted_r <= tok_end.found ? 3'(tok_end.gidx) : 3'd0;
      out_frag_r    <= tok_end.found ? 16'(tok_end.gsize - ctl_r.req) : 16'd0;
      out_free_r    <= 19'(final_sum);
      out_ev_r      <= ev_r;
      out_evp_r     <= 3'(evp_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_part  = out_granted_r;
  assign out_internal_frag = out_frag_r;
  assign out_free_total    = out_free_r;
  assign out_evicted       = out_ev_r;
  assign out_evicted_part  = out_evp_r;

  // Assertions
  a_busy_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (busy_cnt_r <= searched_c))
    else $error("busy count exceeds searched partitions");

  a_tok_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok_end.vld |-> (state_r == S_RUN))
    else $error("pass token left the chain outside a run");

  a_grant_is_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_end.vld && tok_end.found) |-> (ctl_r.op == OP_ALLOC))
    else $error("partition claimed by a non-allocate pass");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_LOOK))
    else $error("accepted request did not start a table lookup");

endmodule

[design/fpff_cell.sv]
// -----------------------------------------------------------------------------
// fpff_cell
// One partition: size and busy flag, first-fit claim and running totals.
// -----------------------------------------------------------------------------
module fpff_cell import fpff_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  token_t    tok_in,
  output token_t    tok_out
);

  localparam logic [PIDX_W-1:0] MY_IDX = PIDX_W'(IDX);
  localparam logic [CNT_W-1:0]  MY_CNT = CNT_W'(IDX);

  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 busy_r, busy_nxt;
  token_t               tok_r, tok_nxt;

  logic                 in_range;
  logic                 busy_eff;
  logic                 claim;
  logic [SIZE_BITS-1:0] size_eff;

  always_comb begin
    in_range = MY_CNT < ctl.searched;
    busy_eff = busy_r & ~(ctl.free_en & (ctl.free_idx == MY_IDX));
    size_eff = ((ctl.op == OP_DEFINE) && (ctl.def_idx == MY_IDX)) ? ctl.def_size : size_r;
    claim    = (ctl.op == OP_ALLOC) && in_range && !busy_eff &&
               (size_eff >= ctl.req) && !tok_in.found;
    busy_nxt = busy_eff | claim;
    size_nxt = size_eff;

    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found | claim;
    if (claim) begin
      tok_nxt.gidx  = MY_IDX;
      tok_nxt.gsize = size_eff;
    end
    // accumulate free space before the claim, busy count after it
    if (in_range && !busy_eff) begin
      tok_nxt.sum = tok_in.sum + SUM_W'(size_eff);
    end
    if (in_range && busy_nxt) begin
      tok_nxt.bcnt = tok_in.bcnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      busy_r <= 1'b0;
      tok_r  <= '0;
    end else if (tok_in.vld) begin
      size_r <= size_nxt;
      busy_r <= busy_nxt;
      tok_r  <= tok_nxt;
    end else begin
      tok_r.vld <= 1'b0;
    end
  end

  assign tok_out = tok_r;

endmodule

[design/fpff_chain.sv]
// -----------------------------------------------------------------------------
// fpff_chain
// Row of partition cells; a pass token walks from cell 0 to the last cell.
// -----------------------------------------------------------------------------
module fpff_chain import fpff_pkg::*; #(
  parameter int NUM_PARTS = NUM_PARTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  token_t    tok_start,
  output token_t    tok_end
);

  token_t link [NUM_PARTS+1];

  assign link[0] = tok_start;

  for (genvar k = 0; k < NUM_PARTS; k++) begin : g_cell
    fpff_cell #(
      .IDX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tok_in (link[k]),
      .tok_out(link[k+1])
    );
  end

  assign tok_end = link[NUM_PARTS];

endmodule

[design/fpff_ptab.sv]
// -----------------------------------------------------------------------------
// fpff_ptab
// Process table: holds flags in flops, partition of each process in memory.
// -----------------------------------------------------------------------------
module fpff_ptab import fpff_pkg::*; #(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ID_W-1:0]   rd_id,
  output logic [PIDX_W-1:0] rd_part,
  input  logic [ID_W-1:0]   pid,
  input  logic [ID_W-1:0]   vid,
  output logic              pid_holds,
  output logic              vid_holds,
  input  ptab_upd_t         upd
);

  localparam int PROC_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  logic [NUM_PROCS-1:0] holds_r, holds_nxt;
  logic [PIDX_W-1:0]    part_mem [NUM_PROCS];
  logic [PIDX_W-1:0]    rd_part_r;

  assign pid_holds = (int'(pid) < NUM_PROCS) && holds_r[PROC_W'(pid)];
  assign vid_holds = (int'(vid) < NUM_PROCS) && holds_r[PROC_W'(vid)];

  always_comb begin
    holds_nxt = holds_r;
    if (upd.set_en) begin
      holds_nxt[PROC_W'(upd.set_id)] = 1'b1;
    end
    if (upd.clr_en) begin
      holds_nxt[PROC_W'(upd.clr_id)] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holds_r <= '0;
    end else begin
      holds_r <= holds_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.set_en) begin
      part_mem[PROC_W'(upd.set_id)] <= upd.set_part;
    end
    if (rd_en) begin
      rd_part_r <= part_mem[PROC_W'(rd_id)];
    end
  end

  assign rd_part = rd_part_r;

endmodule

[bench/tb_fixed_partition_first_fit.sv]
// -----------------------------------------------------------------------------
// tb_fixed_partition_first_fit
// Self-checking bench for the fixed-partition first-fit allocator.
// The bench sends define, allocate and release requests. A bench-side copy of
// the partition table predicts the status, grant, fragmentation, free total
// and eviction of every request. A monitor compares each result with the
// oldest prediction. Both channels stall at random. One long receiver hold
// fills the block up. blocks_in_use is swept across its extremes while the
// block is idle.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_partition_first_fit import fpff_pkg::*;;

  typedef struct packed {
    mode_t                mode;
    logic [2:0]           part_index;
    logic [SIZE_BITS-1:0] part_size;
    logic [ID_W-1:0]      proc_id;
    logic [SIZE_BITS-1:0] proc_size;
    logic [ID_W-1:0]      victim_id;
  } request_t;

  typedef struct packed {
    status_t              status;
    logic [2:0]           granted_part;
    logic [SIZE_BITS-1:0] internal_frag;
    logic [18:0]          free_total;
    logic                 evicted;
    logic [2:0]           evicted_part;
  } outcome_t;

  // A register write starts a recount pass that gives no result. Twice one
  // request slot is ample settle time for it.
  localparam int SETTLE_CYCLES = 2 * (NUM_PARTS_DEF + 3);
  // Receiver hold that backs the block up.
  localparam int LONG_HOLD = 150;
  // Slowest correct run: about 1450 requests, each with its longest send gap,
  // its slot and its longest result stall, plus holds and drains. The limit
  // allows several times that run.
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  request_t    drive_req;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [2:0]  out_granted_part;
  logic [15:0] out_internal_frag;
  logic [18:0] out_free_total;
  logic        out_evicted;
  logic [2:0]  out_evicted_part;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_blocks_in_use;

  fixed_partition_first_fit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (drive_req.mode),
    .in_part_index    (drive_req.part_index),
    .in_part_size     (drive_req.part_size),
    .in_proc_id       (drive_req.proc_id),
    .in_proc_size     (drive_req.proc_size),
    .in_victim_id     (drive_req.victim_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_granted_part (out_granted_part),
    .out_internal_frag(out_internal_frag),
    .out_free_total   (out_free_total),
    .out_evicted      (out_evicted),
    .out_evicted_part (out_evicted_part),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_blocks_in_use(cfg_blocks_in_use)
  );

  // ---------------------------------------------------------------------------
  // Bench copy of the allocator state
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0] size_tab  [NUM_PARTS_DEF];
  bit                   busy_tab  [NUM_PARTS_DEF];
  logic [2:0]           owner_part[NUM_PROCS_DEF];
  bit                   owns      [NUM_PROCS_DEF];
  int                   free_acc;
  int                   busy_acc;
  logic [3:0]           blocks_cfg;

  // Predicted results in request order
  outcome_t expected_q[$];

  // Run bookkeeping
  bit calm;
  int holds_asked;
  int mismatch_count;
  int requests_sent;
  int settings_seen;
  int eviction_count;
  int status_tally[6];

  // Clamp the register to the number of partitions actually searched.
  function automatic int searched_parts();
    int b;
    b = int'(blocks_cfg);
    if (b == 0) b = 1;
    if (b > NUM_PARTS_DEF) b = NUM_PARTS_DEF;
    return b;
  endfunction

  // Rebuild the free total and the busy count over the searched range.
  function automatic void recount_free();
    free_acc = 0;
    busy_acc = 0;
    for (int k = 0; k < searched_parts(); k++) begin
      if (busy_tab[k]) busy_acc++;
      else free_acc += int'(size_tab[k]);
    end
  endfunction

  // Free a partition. Only a partition in the searched range moves the totals.
  function automatic void vacate_part(int p);
    busy_tab[p] = 1'b0;
    if (p < searched_parts()) begin
      free_acc += int'(size_tab[p]);
      busy_acc--;
    end
  endfunction

  // Apply one request to the bench state and return the result it must cause.
  function automatic outcome_t apply_request(request_t r);
    outcome_t o;
    int       b;
    int       req;
    bit       room;
    o = '0;
    o.status = ST_INVALID;
    b = searched_parts();
    req = int'(r.proc_size);
    case (r.mode)
      MODE_DEFINE: begin
        // A busy partition or one outside the range keeps the free total.
        if (!busy_tab[r.part_index] && int'(r.part_index) < b)
          free_acc = free_acc - int'(size_tab[r.part_index]) + int'(r.part_size);
        size_tab[r.part_index] = r.part_size;
        o.status = ST_DEFINED;
      end
      MODE_ALLOC: begin
        if (!owns[r.proc_id]) begin
          room = 1'b1;
          // Every searched partition is taken: swap the victim out first.
          if (busy_acc >= b) begin
            if (owns[r.victim_id]) begin
              o.evicted_part = owner_part[r.victim_id];
              vacate_part(int'(owner_part[r.victim_id]));
              owns[r.victim_id] = 1'b0;
              o.evicted = 1'b1;
            end else begin
              room = 1'b0;
            end
          end
          if (room) begin
            o.status = (free_acc >= req) ? ST_EXT_FRAG : ST_NO_MEM;
            for (int k = 0; k < b; k++) begin
              if (!busy_tab[k] && int'(size_tab[k]) >= req) begin
                busy_tab[k] = 1'b1;
                owner_part[r.proc_id] = k[2:0];
                owns[r.proc_id] = 1'b1;
                free_acc -= int'(size_tab[k]);
                busy_acc++;
                o.granted_part = k[2:0];
                o.internal_frag = size_tab[k] - r.proc_size;
                o.status = ST_ALLOC;
                break;
              end
            end
          end
        end
      end
      MODE_RELEASE: begin
        if (owns[r.proc_id]) begin
          vacate_part(int'(owner_part[r.proc_id]));
          owns[r.proc_id] = 1'b0;
          o.status = ST_RELEASED;
        end
      end
      default: ;
    endcase
    o.free_total = free_acc[18:0];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------
  // Fill every field at random so that unused fields toggle too.
  function automatic request_t noise_request();
    request_t r;
    r.mode       = mode_t'($urandom_range(0, 3));
    r.part_index = 3'($urandom);
    r.part_size  = SIZE_BITS'($urandom);
    r.proc_id    = ID_W'($urandom);
    r.proc_size  = SIZE_BITS'($urandom);
    r.victim_id  = ID_W'($urandom);
    return r;
  endfunction

  function automatic request_t mk_define(int idx, int sz);
    request_t r;
    r = noise_request();
    r.mode       = MODE_DEFINE;
    r.part_index = idx[2:0];
    r.part_size  = sz[SIZE_BITS-1:0];
    return r;
  endfunction

  function automatic request_t mk_alloc(int pid, int sz, int vid);
    request_t r;
    r = noise_request();
    r.mode      = MODE_ALLOC;
    r.proc_id   = pid[ID_W-1:0];
    r.proc_size = sz[SIZE_BITS-1:0];
    r.victim_id = vid[ID_W-1:0];
    return r;
  endfunction

  function automatic request_t mk_release(int pid);
    request_t r;
    r = noise_request();
    r.mode    = MODE_RELEASE;
    r.proc_id = pid[ID_W-1:0];
    return r;
  endfunction

  // Pick a process that holds a partition (or one that does not); fall back
  // to any id when there is no such process.
  function automatic logic [ID_W-1:0] pick_proc(bit holding);
    logic [ID_W-1:0] ids[$];
    for (int p = 0; p < NUM_PROCS_DEF; p++)
      if (owns[p] == holding) ids.push_back(p[ID_W-1:0]);
    if (ids.size() == 0) return ID_W'($urandom);
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Sizes near the partition sizes make fits and near misses likely.
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int base;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SIZE_BITS'($urandom);
      3, 4, 5: return SIZE_BITS'($urandom_range(0, 400));
      default: begin
        base = int'(size_tab[$urandom_range(0, NUM_PARTS_DEF - 1)])
             - int'($urandom_range(0, 30)) + int'($urandom_range(0, 1));
        if (base < 0) base = 0;
        if (base > 65535) base = 65535;
        return base[SIZE_BITS-1:0];
      end
    endcase
  endfunction

  // Mostly well-formed traffic: allocate idle processes, evict and release
  // holders. Leave some wrong ids and unused modes in as noise.
  function automatic request_t random_request();
    request_t r;
    int       pick;
    r = noise_request();
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.mode = MODE_DEFINE;
      r.part_size = pick_size();
    end else if (pick < 62) begin
      r.mode = MODE_ALLOC;
      if ($urandom_range(0, 9) != 0) r.proc_id = pick_proc(1'b0);
      r.proc_size = pick_size();
      if ($urandom_range(0, 7) != 0) r.victim_id = pick_proc(1'b1);
    end else if (pick < 95) begin
      r.mode = MODE_RELEASE;
      if ($urandom_range(0, 7) != 0) r.proc_id = pick_proc(1'b1);
    end else begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------
  // Offer one request, with an optional idle burst first. Hold it until it is
  // taken, then record the prediction.
  task automatic send_request(request_t r);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    drive_req = r;
    in_valid  = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(apply_request(r));
    requests_sent++;
  endtask

  // Drop valid, wait for every pending result, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write blocks_in_use while the block is idle.
  task automatic write_blocks_in_use(logic [3:0] value);
    wait_drained();
    @(negedge clk);
    cfg_blocks_in_use = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    blocks_cfg = value;
    recount_free();
    settings_seen++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic string field_diffs(outcome_t want, outcome_t got);
    string s;
    s = "";
    if (got.status !== want.status)
      s = {s, $sformatf(" status exp %0d got %0d", want.status, got.status)};
    if (got.granted_part !== want.granted_part)
      s = {s, $sformatf(" granted_part exp %0d got %0d", want.granted_part,
                        got.granted_part)};
    if (got.internal_frag !== want.internal_frag)
      s = {s, $sformatf(" internal_frag exp %0d got %0d", want.internal_frag,
                        got.internal_frag)};
    if (got.free_total !== want.free_total)
      s = {s, $sformatf(" free_total exp %0d got %0d", want.free_total,
                        got.free_total)};
    if (got.evicted !== want.evicted)
      s = {s, $sformatf(" evicted exp %0d got %0d", want.evicted, got.evicted)};
    if (got.evicted_part !== want.evicted_part)
      s = {s, $sformatf(" evicted_part exp %0d got %0d", want.evicted_part,
                        got.evicted_part)};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, watchdog, receiver stall and result monitor
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // End the run if it hangs.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             expected_q.size());
    $display("FAIL");
    $finish;
  end

  // Receiver: random stall bursts, plus a long hold whenever a test asks.
  // The hold is counted here so the sender can keep pushing meanwhile.
  initial begin
    int burst_left;
    int hold_left;
    int holds_served;
    burst_left   = 0;
    hold_left    = 0;
    holds_served = 0;
    out_stall    = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 10) begin
        burst_left = $urandom_range(1, 18) - 1;
        out_stall  = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    string    diffs;
    if (rst_n && out_valid && !out_stall) begin
      got.status        = status_t'(out_status);
      got.granted_part  = out_granted_part;
      got.internal_frag = out_internal_frag;
      got.free_total    = out_free_total;
      got.evicted       = out_evicted;
      got.evicted_part  = out_evicted_part;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %p", got));
      end else begin
        want  = expected_q.pop_front();
        diffs = field_diffs(want, got);
        if (diffs != "") begin
          report_mismatch(diffs);
        end else begin
          if (int'(got.status) < 6) status_tally[int'(got.status)]++;
          if (got.evicted) eviction_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Walk the special cases from reset. Sizes start at zero and all eight
  // partitions are searched.
  task automatic test_directed_cases();
    request_t r;
    r = noise_request();
    r.mode = MODE_UNUSED;
    send_request(r);                              // unused mode
    send_request(mk_release(5));                  // release of a non-holder
    send_request(mk_alloc(0, 0, 0));              // zero request in a zero partition
    send_request(mk_alloc(0, 1, 3));              // process already holds one
    send_request(mk_define(7, 16'hFFFF));         // largest size
    send_request(mk_define(1, 100));
    send_request(mk_define(2, 300));
    send_request(mk_define(0, 50));               // resize a busy partition
    send_request(mk_alloc(1, 16'hFFFF, 0));       // exact fit of the largest request
    send_request(mk_alloc(2, 200, 0));            // fit with internal fragmentation
    send_request(mk_alloc(3, 1000, 0));           // not enough memory at all
    send_request(mk_alloc(4, 60, 0));
    send_request(mk_alloc(3, 0, 0));              // fill the remaining partitions
    send_request(mk_alloc(5, 0, 0));
    send_request(mk_alloc(6, 0, 0));
    send_request(mk_alloc(15, 0, 0));
    send_request(mk_alloc(8, 10, 9));             // full, victim holds nothing
    send_request(mk_alloc(8, 16'hFFFF, 1));       // full, evict then grant
    send_request(mk_alloc(9, 16'hFFFF, 2));       // evicted, still no room
    send_request(mk_release(4));
    send_request(mk_alloc(11, 350, 0));           // enough in total, no single fit
    send_request(mk_release(8));
    send_request(mk_alloc(12, 16'hFFFF, 14));     // largest request, largest free part
  endtask

  // Narrow and widen the searched range, including 0 and 15. Partitions and
  // holders outside the range stay around across the changes.
  task automatic test_register_sweep();
    logic [3:0] sweep[6];
    sweep = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd2};
    foreach (sweep[i]) begin
      write_blocks_in_use(sweep[i]);
      send_request(mk_define(7, $urandom_range(0, 400)));  // often outside the range
      repeat (30) send_request(random_request());
    end
  endtask

  // Hold the receiver off and keep offering requests back to back, so the
  // block fills and stalls its input.
  task automatic test_backpressure();
    write_blocks_in_use(4'd8);
    calm = 1'b1;
    holds_asked++;
    repeat (30) send_request(random_request());
    calm = 1'b0;
  endtask

  // Bulk random traffic with a fresh register value now and then.
  task automatic test_random_traffic(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 249) write_blocks_in_use(4'($urandom));
      send_request(random_request());
    end
  endtask

  // Finish with no idling on either side.
  task automatic test_quiet_tail(int count);
    write_blocks_in_use(4'd8);
    calm = 1'b1;
    repeat (count) send_request(random_request());
  endtask

  initial begin
    // Hold every input at a known value through reset.
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    drive_req         = '0;
    cfg_valid         = 1'b0;
    cfg_blocks_in_use = 4'd8;
    calm              = 1'b0;
    holds_asked       = 0;
    mismatch_count    = 0;
    requests_sent     = 0;
    settings_seen     = 1;
    eviction_count    = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (size_tab[i]) begin
      size_tab[i] = '0;
      busy_tab[i] = 1'b0;
    end
    foreach (owns[i]) begin
      owns[i]       = 1'b0;
      owner_part[i] = '0;
    end
    blocks_cfg = 4'd8;
    recount_free();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_register_sweep();
    test_backpressure();
    test_random_traffic(1050);
    test_quiet_tail(120);
    wait_drained();

    $display("Covered %0d requests over %0d register settings, with one %0d-cycle hold.",
             requests_sent, settings_seen, LONG_HOLD);
    $display("Seen: %0d granted, %0d ext-frag, %0d short, %0d defined,",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
    $display("      %0d released, %0d invalid, %0d evicted.",
             status_tally[4], status_tally[5], eviction_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
